FILE: rtl/der_tlv_pkg.sv
// ----------------------------------------------------------------------------
// der_tlv_pkg
// Shared types and constants for the DER TLV stream decoder.
// ----------------------------------------------------------------------------
package der_tlv_pkg;

  // default number of long-form length octets accepted
  localparam int LENGTH_BYTES_MAX_DEF = 4;

  // depth of the queue between parser and output stage
  localparam int Q_DEPTH = 2;

  // tag octet limits and length octet codes
  localparam logic [7:0] TAG_MIN        = 8'd1;
  localparam logic [7:0] TAG_MAX        = 8'd30;
  localparam logic [7:0] COUNT_RESERVED = 8'hFF;
  localparam logic [7:0] COUNT_MASK     = 8'h7F;
  localparam int         LONG_FORM_BIT  = 7;

  // parser phase
  typedef enum logic [1:0] {
    PH_TAG    = 2'd0,
    PH_LEN    = 2'd1,
    PH_LENOCT = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  // result kind
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // error codes
  localparam logic [1:0] ERR_BAD_TAG   = 2'd0;
  localparam logic [1:0] ERR_RESERVED  = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

  // compact result held in the queue; data is length, byte or error code
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  tag;
    logic [31:0] data;
    logic        last;
  } entry_t;

  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // queue status seen by the parser and the output stage
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

endpackage

FILE: rtl/der_tlv_if.sv
// ----------------------------------------------------------------------------
// der_tlv_if
// Octet input channel and result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface der_tlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface der_tlv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [4:0]  element_tag;
  logic [31:0] element_length;
  logic [7:0]  content_byte;
  logic        last_of_element;
  logic [1:0]  fault_code;

  modport source (output valid, output result_kind, output element_tag,
                  output element_length, output content_byte,
                  output last_of_element, output fault_code, input ready);
  modport sink   (input valid, input result_kind, input element_tag,
                  input element_length, input content_byte,
                  input last_of_element, input fault_code, output ready);
endinterface

FILE: rtl/der_tlv_stream_decoder.sv
// ----------------------------------------------------------------------------
// der_tlv_stream_decoder
// DER TLV stream parser, one octet per cycle while the queue has room, with
// header, content and error requests on the result channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one DER octet per request. Each octet yields zero or one
//   result on out_ch: an element header (tag and length), a content byte
//   (marked last on the element's final octet), or an error report. Good
//   tags, nonzero in-range long-form counts and non-final length octets
//   yield no result. Throughput is one octet per cycle while the queue has
//   room. The parser updates its state in the same cycle an octet is taken
//   and pushes its result into a two-entry queue, from which the output
//   register loads it whenever that register is empty or being taken.
//   When the receiver stalls, the queue fills and in_ch.ready drops once it
//   holds two results; octets that yield no result still need a free slot.
//   Synchronous reset (rst_n low) returns the parser to the tag phase,
//   empties the queue and clears out_ch.valid.
// ----------------------------------------------------------------------------
module der_tlv_stream_decoder #(
  parameter int LENGTH_BYTES_MAX = der_tlv_pkg::LENGTH_BYTES_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  der_tlv_in_if.sink    in_ch,
  der_tlv_out_if.source out_ch
);

  der_tlv_pkg::entry_t  push_entry;
  der_tlv_pkg::entry_t  head;
  der_tlv_pkg::q_stat_t q_stat;
  logic                 push;
  logic                 pop;

  // parser
  der_tlv_front #(
    .LENGTH_BYTES_MAX(LENGTH_BYTES_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  der_tlv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // output stage
  der_tlv_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // no push into a full queue
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  // no pop from an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // fill count stays within depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= der_tlv_pkg::Q_CNT_W'(der_tlv_pkg::Q_DEPTH))
    else $error("queue count overflow");

  // a header marked last carries a zero length
  a_hdr_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind == 2'(der_tlv_pkg::KIND_HEADER)
      && out_ch.last_of_element) |-> out_ch.element_length == 32'd0)
    else $error("last header with nonzero length");

  // output valid is low right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

FILE: rtl/der_tlv_front.sv
// ----------------------------------------------------------------------------
// der_tlv_front
// Octet parser: tracks the TLV phase and turns each octet into at most one
// compact result pushed into the queue.
// ----------------------------------------------------------------------------
module der_tlv_front #(
  parameter int LENGTH_BYTES_MAX = der_tlv_pkg::LENGTH_BYTES_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  der_tlv_in_if.sink           in_ch,
  input  der_tlv_pkg::q_stat_t q_stat,
  output logic                 push,
  output der_tlv_pkg::entry_t  push_entry
);

  localparam int OCT_W = $clog2(LENGTH_BYTES_MAX + 1);

  der_tlv_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]          tag_r, tag_nxt;
  logic [31:0]         accum_r, accum_nxt;
  logic [OCT_W-1:0]    oct_left_r, oct_left_nxt;
  logic [31:0]         body_left_r, body_left_nxt;

  logic       accept;
  logic       has_result;
  logic [7:0] b;
  logic [6:0] count;
  logic [31:0] hdr_len;
  logic        hdr_go;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign count       = b[6:0] & der_tlv_pkg::COUNT_MASK[6:0];
  assign push        = accept && has_result;

  // next state and result for the current octet
  always_comb begin
    phase_nxt     = phase_r;
    tag_nxt       = tag_r;
    accum_nxt     = accum_r;
    oct_left_nxt  = oct_left_r;
    body_left_nxt = body_left_r;
    has_result    = 1'b0;
    hdr_go        = 1'b0;
    hdr_len       = 32'd0;
    push_entry    = '{kind: der_tlv_pkg::KIND_ERROR, tag: 5'd0, data: 32'd0, last: 1'b0};

    case (phase_r)
      der_tlv_pkg::PH_TAG: begin
        if (b >= der_tlv_pkg::TAG_MIN && b <= der_tlv_pkg::TAG_MAX) begin
          tag_nxt   = b[4:0];
          phase_nxt = der_tlv_pkg::PH_LEN;
        end else begin
          has_result      = 1'b1;
          push_entry.data = 32'(der_tlv_pkg::ERR_BAD_TAG);
        end
      end
      der_tlv_pkg::PH_LEN: begin
        if (!b[der_tlv_pkg::LONG_FORM_BIT]) begin
          hdr_go  = 1'b1;
          hdr_len = 32'(b);
        end else if (b == der_tlv_pkg::COUNT_RESERVED) begin
          has_result      = 1'b1;
          push_entry.tag  = tag_r;
          push_entry.data = 32'(der_tlv_pkg::ERR_RESERVED);
        end else if (count > 7'(LENGTH_BYTES_MAX)) begin
          has_result      = 1'b1;
          push_entry.tag  = tag_r;
          push_entry.data = 32'(der_tlv_pkg::ERR_TOO_LONG);
        end else if (count == 7'd0) begin
          hdr_go  = 1'b1;
          hdr_len = 32'd0;
        end else begin
          accum_nxt    = 32'd0;
          oct_left_nxt = count[OCT_W-1:0];
          phase_nxt    = der_tlv_pkg::PH_LENOCT;
        end
      end
      der_tlv_pkg::PH_LENOCT: begin
        // big-endian accumulate; earliest octets fall off the top
        accum_nxt = {accum_r[23:0], b};
        if (oct_left_r != '0) begin
          oct_left_nxt = oct_left_r - OCT_W'(1);
        end
        if (oct_left_nxt == '0) begin
          hdr_go  = 1'b1;
          hdr_len = accum_nxt;
        end
      end
      der_tlv_pkg::PH_BODY: begin
        if (body_left_r != 32'd0) begin
          body_left_nxt = body_left_r - 32'd1;
        end
        has_result      = 1'b1;
        push_entry.kind = der_tlv_pkg::KIND_BYTE;
        push_entry.tag  = tag_r;
        push_entry.data = 32'(b);
        if (body_left_nxt == 32'd0) begin
          push_entry.last = 1'b1;
          phase_nxt       = der_tlv_pkg::PH_TAG;
        end
      end
      default: begin
        phase_nxt = der_tlv_pkg::PH_TAG;
      end
    endcase

    // element header once the length is known
    if (hdr_go) begin
      has_result      = 1'b1;
      push_entry.kind = der_tlv_pkg::KIND_HEADER;
      push_entry.tag  = tag_r;
      push_entry.data = hdr_len;
      if (hdr_len == 32'd0) begin
        push_entry.last = 1'b1;
        phase_nxt       = der_tlv_pkg::PH_TAG;
      end else begin
        body_left_nxt = hdr_len;
        phase_nxt     = der_tlv_pkg::PH_BODY;
      end
    end
  end

  // parse state, updated on every accepted octet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= der_tlv_pkg::PH_TAG;
      tag_r       <= 5'd0;
      accum_r     <= 32'd0;
      oct_left_r  <= '0;
      body_left_r <= 32'd0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      tag_r       <= tag_nxt;
      accum_r     <= accum_nxt;
      oct_left_r  <= oct_left_nxt;
      body_left_r <= body_left_nxt;
    end
  end

endmodule

FILE: rtl/der_tlv_queue.sv
// ----------------------------------------------------------------------------
// der_tlv_queue
// Short register queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module der_tlv_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  der_tlv_pkg::entry_t  push_entry,
  input  logic                 pop,
  output der_tlv_pkg::entry_t  head,
  output der_tlv_pkg::q_stat_t stat
);

  localparam int AW = (der_tlv_pkg::Q_DEPTH > 1) ? $clog2(der_tlv_pkg::Q_DEPTH) : 1;
  localparam int CW = der_tlv_pkg::Q_CNT_W;

  der_tlv_pkg::entry_t mem_r [der_tlv_pkg::Q_DEPTH];
  logic [AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]       count_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(der_tlv_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(der_tlv_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(der_tlv_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/der_tlv_back.sv
// ----------------------------------------------------------------------------
// der_tlv_back
// Output stage: takes compact results from the queue and presents them as
// full result fields in an output register.
// ----------------------------------------------------------------------------
module der_tlv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  der_tlv_pkg::entry_t  head,
  input  der_tlv_pkg::q_stat_t q_stat,
  output logic                 pop,
  der_tlv_out_if.source        out_ch
);

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [4:0]  tag_r;
  logic [31:0] len_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [1:0]  err_r;

  logic [1:0]  kind_nxt;
  logic [31:0] len_nxt;
  logic [7:0]  byte_nxt;
  logic [1:0]  err_nxt;

  assign pop = !q_stat.empty && (!valid_r || out_ch.ready);

  // expand the packed data word by kind
  always_comb begin
    kind_nxt = 2'(head.kind);
    len_nxt  = 32'd0;
    byte_nxt = 8'd0;
    err_nxt  = 2'd0;
    case (head.kind)
      der_tlv_pkg::KIND_HEADER: len_nxt  = head.data;
      der_tlv_pkg::KIND_BYTE:   byte_nxt = head.data[7:0];
      der_tlv_pkg::KIND_ERROR:  err_nxt  = head.data[1:0];
      default:                  kind_nxt = 2'(der_tlv_pkg::KIND_ERROR);
    endcase
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= kind_nxt;
      tag_r  <= head.tag;
      len_r  <= len_nxt;
      byte_r <= byte_nxt;
      last_r <= head.last;
      err_r  <= err_nxt;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.result_kind     = kind_r;
  assign out_ch.element_tag     = tag_r;
  assign out_ch.element_length  = len_r;
  assign out_ch.content_byte    = byte_r;
  assign out_ch.last_of_element = last_r;
  assign out_ch.fault_code      = err_r;

endmodule

FILE: tb/der_tlv_stream_decoder_checker.sv
// ----------------------------------------------------------------------------
// der_tlv_stream_decoder_checker
// Watches the octet and result channels of the DER TLV decoder, parses every
// accepted octet with its own TLV parser and compares each accepted result
// field by field against the oldest parsed result still waiting.
// ----------------------------------------------------------------------------
module der_tlv_stream_decoder_checker #(
  parameter int LEN_MAX = der_tlv_pkg::LENGTH_BYTES_MAX_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  der_tlv_in_if  in_mon,
  der_tlv_out_if out_mon,
  output int     mismatch_count,
  output int     results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    der_tlv_pkg::kind_t kind;
    logic [4:0]         tag;
    logic [31:0]        length;
    logic [7:0]         cbyte;
    logic               last;
    logic [1:0]         err;
  } tlv_result_t;

  // parser state
  der_tlv_pkg::phase_t parse_phase;
  logic [4:0]          tag_held;
  logic [31:0]         length_accum;
  logic [3:0]          octets_left;
  logic [31:0]         content_left;

  tlv_result_t parsed_results[$];
  int          flaw_total;

  function automatic tlv_result_t make_result(der_tlv_pkg::kind_t kind, logic [4:0] tag,
                                              logic [31:0] length, logic [7:0] cbyte,
                                              logic last, logic [1:0] err);
    tlv_result_t res;
    res.kind   = kind;
    res.tag    = tag;
    res.length = length;
    res.cbyte  = cbyte;
    res.last   = last;
    res.err    = err;
    return res;
  endfunction

  // header for a complete length; empty elements end right here
  function automatic tlv_result_t start_element(logic [31:0] length);
    if (length == 0) begin
      parse_phase = der_tlv_pkg::PH_TAG;
      return make_result(der_tlv_pkg::KIND_HEADER, tag_held, '0, '0, 1'b1, '0);
    end
    content_left = length;
    parse_phase  = der_tlv_pkg::PH_BODY;
    return make_result(der_tlv_pkg::KIND_HEADER, tag_held, length, '0, 1'b0, '0);
  endfunction

  // advance the parse by one octet; returns 1 when a result is produced
  function automatic bit parse_octet(input logic [7:0] octet, output tlv_result_t res);
    logic [6:0] count;
    case (parse_phase)
      der_tlv_pkg::PH_TAG: begin
        if (octet >= der_tlv_pkg::TAG_MIN && octet <= der_tlv_pkg::TAG_MAX) begin
          tag_held    = octet[4:0];
          parse_phase = der_tlv_pkg::PH_LEN;
          return 1'b0;
        end
        res = make_result(der_tlv_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
                          der_tlv_pkg::ERR_BAD_TAG);
        return 1'b1;
      end
      der_tlv_pkg::PH_LEN: begin
        if (!octet[der_tlv_pkg::LONG_FORM_BIT]) begin
          res = start_element({24'd0, octet});
          return 1'b1;
        end
        if (octet == der_tlv_pkg::COUNT_RESERVED) begin
          res = make_result(der_tlv_pkg::KIND_ERROR, tag_held, '0, '0, 1'b0,
                            der_tlv_pkg::ERR_RESERVED);
          return 1'b1;
        end
        count = 7'(octet & der_tlv_pkg::COUNT_MASK);
        if (count > LEN_MAX) begin
          res = make_result(der_tlv_pkg::KIND_ERROR, tag_held, '0, '0, 1'b0,
                            der_tlv_pkg::ERR_TOO_LONG);
          return 1'b1;
        end
        if (count == 0) begin
          res = start_element('0);
          return 1'b1;
        end
        length_accum = '0;
        octets_left  = count[3:0];
        parse_phase  = der_tlv_pkg::PH_LENOCT;
        return 1'b0;
      end
      der_tlv_pkg::PH_LENOCT: begin
        // big-endian accumulate, oldest octets fall off the top
        length_accum = {length_accum[23:0], octet};
        if (octets_left > 0) octets_left = octets_left - 1'b1;
        if (octets_left != 0) return 1'b0;
        res = start_element(length_accum);
        return 1'b1;
      end
      default: begin
        if (content_left > 0) content_left = content_left - 1;
        res = make_result(der_tlv_pkg::KIND_BYTE, tag_held, '0, octet,
                          content_left == 0, '0);
        if (content_left == 0) parse_phase = der_tlv_pkg::PH_TAG;
        return 1'b1;
      end
    endcase
  endfunction

  // parse accepted octets, then check accepted results
  always @(posedge clk) begin
    tlv_result_t want;
    tlv_result_t got;
    if (!rst_n) begin
      parse_phase  = der_tlv_pkg::PH_TAG;
      tag_held     = '0;
      length_accum = '0;
      octets_left  = '0;
      content_left = '0;
      parsed_results.delete();
      flaw_total   = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (parse_octet(in_mon.data_byte, want)) parsed_results.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = make_result(der_tlv_pkg::kind_t'(out_mon.result_kind), out_mon.element_tag,
                          out_mon.element_length, out_mon.content_byte,
                          out_mon.last_of_element, out_mon.fault_code);
        if (parsed_results.size() == 0) begin
          flaw_total++;
          if (flaw_total <= 10)
            $display("%0t: result request with none pending: kind %0d tag %0d len %0d",
                     $realtime, got.kind, got.tag, got.length);
        end else begin
          want = parsed_results.pop_front();
          if (got.kind !== want.kind || got.tag !== want.tag ||
              got.length !== want.length || got.cbyte !== want.cbyte ||
              got.last !== want.last || got.err !== want.err) begin
            flaw_total++;
            if (flaw_total <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected kind %0d tag %0d len %0d byte %02h last %0d err %0d",
                       want.kind, want.tag, want.length, want.cbyte, want.last, want.err);
              $display("  actual   kind %0d tag %0d len %0d byte %02h last %0d err %0d",
                       got.kind, got.tag, got.length, got.cbyte, got.last, got.err);
            end
          end
        end
      end
    end
    mismatch_count      <= flaw_total;
    results_outstanding <= parsed_results.size();
  end

endmodule

FILE: tb/der_tlv_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// der_tlv_stream_decoder_test
// Feeds the DER TLV decoder a directed octet stream followed by random
// well-formed elements mixed with bad tags and bad length counts, with bursty
// input requests and a stalling receiver; the checker judges every result.
// ----------------------------------------------------------------------------
module der_tlv_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_MAX        = der_tlv_pkg::LENGTH_BYTES_MAX_DEF;
  localparam int RANDOM_OCTETS  = 1950;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 300000;

  typedef enum int {
    ALWAYS_READY,
    COIN_FLIP,
    ONE_IN_FOUR,
    MOSTLY_READY
  } stall_pattern_t;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   mismatch_count;
  int   results_outstanding;

  logic [7:0] octet_stream[$];

  der_tlv_in_if  in_ch();
  der_tlv_out_if out_ch();

  der_tlv_stream_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  der_tlv_stream_decoder_checker #(.LEN_MAX(LEN_MAX)) checker_inst (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mon              (in_ch),
    .out_mon             (out_ch),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // append tag, optional bad length octet, length field and body octets
  task automatic push_element(input int tag, input int junk, input logic [31:0] length,
                              input int n_len, input int body);
    octet_stream.push_back(8'(tag));
    if (junk >= 0) octet_stream.push_back(8'(junk));
    if (n_len == 0) begin
      octet_stream.push_back(length[7:0]);
    end else begin
      octet_stream.push_back(8'(8'h80 | n_len));
      for (int i = n_len - 1; i >= 0; i--) octet_stream.push_back(8'(length >> (8 * i)));
    end
    repeat (body) octet_stream.push_back(8'($urandom_range(0, 255)));
  endtask

  // receiver stall patterns, switched after a random span
  initial begin
    stall_pattern_t pattern;
    int span;
    int tick;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      pattern = stall_pattern_t'($urandom_range(0, 3));
      span    = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk);
        case (pattern)
          ALWAYS_READY: out_ch.ready <= 1'b1;
          COIN_FLIP:    out_ch.ready <= 1'($urandom_range(0, 1));
          ONE_IN_FOUR:  out_ch.ready <= (tick % 4 == 0);
          default:      out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
        tick++;
      end
    end
  end

  // stimulus
  initial begin
    int sel;
    int n_len;
    int idx;
    int burst;
    int gap;
    logic [31:0] length;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.data_byte <= '0;

    // directed: bad tags, empty short form, reserved and oversized counts on
    // the top tag, empty long form, one-byte body, two-octet long form,
    // oversized count then padded four-octet long form
    octet_stream = '{8'h00, 8'hFF,
                     8'h01, 8'h00,
                     8'h1E, 8'hFF, 8'h85, 8'h80,
                     8'h02, 8'h01, 8'hAB,
                     8'h04, 8'h82, 8'h00, 8'h02, 8'h55, 8'hAA,
                     8'h03, 8'hFE, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7F};

    // random: mostly well-formed elements, some bad tags and bad counts
    while (octet_stream.size() < 25 + RANDOM_OCTETS) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 6) begin
        n_len  = 0;
        length = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 127) : $urandom_range(0, 15);
      end else begin
        n_len  = $urandom_range(1, LEN_MAX);
        length = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
      end
      if (sel < 8)
        octet_stream.push_back(($urandom_range(0, 3) == 0) ? 8'h00 :
                               8'($urandom_range(31, 255)));
      else if (sel < 13)
        push_element($urandom_range(1, 30), int'(der_tlv_pkg::COUNT_RESERVED),
                     length, n_len, length);
      else if (sel < 18)
        push_element($urandom_range(1, 30), $urandom_range(8'h80 + LEN_MAX + 1, 8'hFE),
                     length, n_len, length);
      else
        push_element($urandom_range(1, 30), -1, length, n_len, length);
    end

    // largest length last, with only a few body octets
    push_element(16, -1, 32'hFFFF_FFFF, 4, 3);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // bursts of requests with random gaps
    idx = 0;
    while (idx < octet_stream.size()) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      while (burst > 0 && idx < octet_stream.size()) begin
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= octet_stream[idx];
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 && idx < octet_stream.size()) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // drain
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/der_tlv_pkg.sv
rtl/der_tlv_if.sv
rtl/der_tlv_front.sv
rtl/der_tlv_queue.sv
rtl/der_tlv_back.sv
rtl/der_tlv_stream_decoder.sv
tb/der_tlv_stream_decoder_checker.sv
tb/der_tlv_stream_decoder_test.sv
